FILE: rtl/core/slhp_pkg.sv
package slhp_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BASELINE     = 3'd2;
  localparam logic [2:0] REG_FOV_TANGENT  = 3'd3;
  localparam logic [2:0] REG_MATRIX_ROW0  = 3'd4;
  localparam logic [2:0] REG_MATRIX_ROW1  = 3'd5;
  localparam logic [2:0] REG_MATRIX_ROW2  = 3'd6;
  localparam logic [2:0] REG_MATRIX_ROW3  = 3'd7;

  localparam int LED_COUNT = 3;

  // Operations of the shared arithmetic unit.
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_MAC = 2'd1;
  localparam logic [1:0] OP_DIV = 2'd2;

  // Extra quotient bits: one for a rounded ratio, seventeen for a Q16 ratio.
  localparam logic [4:0] FRAC_RATIO = 5'd1;
  localparam logic [4:0] FRAC_SCALE = 5'd17;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    logic        sub;
    logic        neg;
    logic [4:0]  frac;
  } alu_req_t;

endpackage

FILE: rtl/core/stereo_led_head_pose.sv
// Stereo LED head pose.
// The input channel (in_valid/in_ready) carries one request per LED: its slot
// number and the matched left and right image points in Q12.4 pixels. The
// output channel (out_valid/out_ready) returns exactly one result request per
// input request: the triangulated point in Q16.16 and, after slot 2, the
// transformed head centroid and altitude vector when pose_valid is set.
// The block works on one request at a time with a single shared unit that
// multiplies by shift-and-add (one multiplier bit per cycle) and divides by
// restoring division (one quotient bit per cycle). A point that completes
// the set adds two transforms of sixteen multiply steps and three divisions
// each. A point at infinity skips the arithmetic.
// The result sits in an output register; while it waits for out_ready the
// next request is accepted and computed, and only its final load waits.
// Synchronous reset returns the sequencer to idle, drops out_valid, clears
// the set-failed flag and loads the configuration defaults. Configuration
// writes through cfg_write take effect at once; the user must make them
// while idle, as the block itself does not enforce this.
module stereo_led_head_pose (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         led_index,
  input  logic [15:0]        left_x,
  input  logic [15:0]        left_y,
  input  logic [15:0]        right_x,
  input  logic [15:0]        right_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] led_x,
  output logic signed [31:0] led_y,
  output logic signed [31:0] led_z,
  output logic               at_infinity,
  output logic               pose_ready,
  output logic               pose_valid,
  output logic signed [31:0] head_x,
  output logic signed [31:0] head_y,
  output logic signed [31:0] head_z,
  output logic signed [31:0] look_x,
  output logic signed [31:0] look_y,
  output logic signed [31:0] look_z
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_XMUL  = 4'd2;
  localparam logic [3:0] S_XDIV  = 4'd3;
  localparam logic [3:0] S_YMUL  = 4'd4;
  localparam logic [3:0] S_YDIV  = 4'd5;
  localparam logic [3:0] S_ZMUL1 = 4'd6;
  localparam logic [3:0] S_ZMUL2 = 4'd7;
  localparam logic [3:0] S_ZDIV  = 4'd8;
  localparam logic [3:0] S_STORE = 4'd9;
  localparam logic [3:0] S_PMAC  = 4'd10;
  localparam logic [3:0] S_PROW  = 4'd11;
  localparam logic [3:0] S_PDIV  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  // Configuration registers.
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [15:0] camera_baseline;
  logic [19:0] half_fov_tangent;
  logic [63:0] matrix_row [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= 13'd640;
      image_height     <= 13'd480;
      camera_baseline  <= 16'd3072;
      half_fov_tangent <= 20'd25814;
      matrix_row[0]    <= 64'h0000_0000_0000_1000;
      matrix_row[1]    <= 64'h0000_0000_1000_0000;
      matrix_row[2]    <= 64'h0000_1000_0000_0000;
      matrix_row[3]    <= 64'h1000_0000_0000_0000;
    end else if (cfg_write) begin
      case (cfg_index)
        slhp_pkg::REG_IMAGE_WIDTH:  image_width      <= cfg_data[12:0];
        slhp_pkg::REG_IMAGE_HEIGHT: image_height     <= cfg_data[12:0];
        slhp_pkg::REG_BASELINE:     camera_baseline  <= cfg_data[15:0];
        slhp_pkg::REG_FOV_TANGENT:  half_fov_tangent <= cfg_data[19:0];
        slhp_pkg::REG_MATRIX_ROW0:  matrix_row[0]    <= cfg_data;
        slhp_pkg::REG_MATRIX_ROW1:  matrix_row[1]    <= cfg_data;
        slhp_pkg::REG_MATRIX_ROW2:  matrix_row[2]    <= cfg_data;
        slhp_pkg::REG_MATRIX_ROW3:  matrix_row[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and captured request.
  logic [3:0]  state;
  logic        issued;
  logic [1:0]  idx;
  logic [15:0] lx;
  logic [15:0] ly;
  logic [15:0] rx;
  logic [15:0] ry;

  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  logic [63:0]        num;
  logic [63:0]        den;
  logic signed [63:0] w_dot;
  logic               set_failed;
  logic               ready_r;
  logic               pvalid;
  logic               pass;
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [31:0] head_r [3];
  logic signed [31:0] look_r [3];

  logic signed [31:0] stored_x [slhp_pkg::LED_COUNT];
  logic signed [31:0] stored_y [slhp_pkg::LED_COUNT];
  logic signed [31:0] stored_z [slhp_pkg::LED_COUNT];

  // Triangulation terms from the captured points.
  logic signed [16:0] d_sig;
  logic               d_neg;
  logic [15:0]        d_mag;
  logic               inf;
  logic [15:0]        w8;
  logic signed [18:0] dl;
  logic signed [18:0] dr;
  logic signed [18:0] sxy;
  logic [18:0]        sxy_mag;
  logic signed [18:0] cm2;
  logic [18:0]        c2;
  logic               same;
  logic               dz_neg;
  logic               x_neg;
  logic               y_neg;

  assign d_sig   = $signed({1'b0, lx}) - $signed({1'b0, rx});
  assign d_neg   = d_sig[16];
  assign d_mag   = d_neg ? 16'(-d_sig) : d_sig[15:0];
  assign inf     = (d_sig == 17'sd0);
  assign w8      = {image_width, 3'b000};
  assign dl      = $signed({3'b000, lx}) - $signed({3'b000, w8});
  assign dr      = $signed({3'b000, rx}) - $signed({3'b000, w8});
  assign sxy     = dl + dr;
  assign sxy_mag = sxy[18] ? 19'(-sxy) : sxy;
  assign cm2     = $signed({3'b000, ly}) + $signed({3'b000, ry})
                 - $signed({2'b00, image_height, 4'b0000});
  assign c2      = cm2[18] ? 19'(-cm2) : cm2;
  assign same    = (dl < 0 && dr < 0) || (dl > 0 && dr > 0);
  // Same side keeps the sign of the disparity; otherwise its magnitude is used.
  assign dz_neg  = same && d_neg;
  // x takes the negated column sum, so a positive sum gives a negative numerator.
  assign x_neg   = (sxy > 0) ^ d_neg;
  assign y_neg   = (cm2 > 0) ^ dz_neg;

  // Transform operands: the centroid sum with w = 3, or the altitude sum with w = 2.
  logic signed [34:0] comp;
  logic signed [63:0] s_sel;
  logic [63:0]        row_sel;
  logic signed [15:0] coef;
  logic [15:0]        coef_mag;

  always_comb begin
    case (col)
      2'd0: begin
        comp = pass ? (35'(stored_x[2]) * 2 - 35'(stored_x[0]) - 35'(stored_x[1]))
                    : (35'(stored_x[0]) + 35'(stored_x[1]) + 35'(stored_x[2]));
      end
      2'd1: begin
        comp = pass ? (35'(stored_y[2]) * 2 - 35'(stored_y[0]) - 35'(stored_y[1]))
                    : (35'(stored_y[0]) + 35'(stored_y[1]) + 35'(stored_y[2]));
      end
      2'd2: begin
        comp = pass ? (35'(stored_z[2]) * 2 - 35'(stored_z[0]) - 35'(stored_z[1]))
                    : (35'(stored_z[0]) + 35'(stored_z[1]) + 35'(stored_z[2]));
      end
      default: begin
        comp = pass ? 35'sh2_0000 : 35'sh3_0000;
      end
    endcase
    s_sel    = 64'(comp);
    row_sel  = matrix_row[row];
    coef     = $signed(row_sel[{col, 4'b0000} +: 16]);
    coef_mag = coef[15] ? 16'(-coef) : coef;
  end

  // Shared unit.
  slhp_pkg::alu_req_t req;
  logic               alu_done;
  logic signed [63:0] alu_acc;
  logic signed [31:0] alu_res;
  logic [63:0]        acc_mag;
  logic [63:0]        w_mag;
  logic               op_state;

  assign acc_mag  = alu_acc[63] ? 64'(-alu_acc) : alu_acc;
  assign w_mag    = w_dot[63] ? 64'(-w_dot) : w_dot;
  assign op_state = (state == S_XMUL) || (state == S_XDIV) || (state == S_YMUL)
                 || (state == S_YDIV) || (state == S_ZMUL1) || (state == S_ZMUL2)
                 || (state == S_ZDIV) || (state == S_PMAC) || (state == S_PDIV);

  always_comb begin
    req       = '0;
    req.start = op_state && !issued;
    req.frac  = slhp_pkg::FRAC_RATIO;
    case (state)
      S_XMUL: begin
        req.op = slhp_pkg::OP_MUL;
        req.a  = 64'(sxy_mag);
        req.b  = 64'(camera_baseline);
      end
      S_XDIV: begin
        req.op  = slhp_pkg::OP_DIV;
        req.a   = num;
        req.b   = 64'(d_mag);
        req.neg = x_neg;
      end
      S_YMUL: begin
        req.op = slhp_pkg::OP_MUL;
        req.a  = 64'(c2);
        req.b  = 64'(camera_baseline);
      end
      S_YDIV: begin
        req.op  = slhp_pkg::OP_DIV;
        req.a   = num;
        req.b   = 64'(d_mag);
        req.neg = y_neg;
      end
      S_ZMUL1: begin
        req.op = slhp_pkg::OP_MUL;
        req.a  = 64'(image_width);
        req.b  = 64'(camera_baseline);
      end
      S_ZMUL2: begin
        req.op = slhp_pkg::OP_MUL;
        req.a  = 64'(d_mag);
        req.b  = 64'(half_fov_tangent);
      end
      S_ZDIV: begin
        req.op  = slhp_pkg::OP_DIV;
        req.a   = num;
        req.b   = den;
        req.neg = dz_neg;
      end
      S_PMAC: begin
        req.op  = (col == 2'd0) ? slhp_pkg::OP_MUL : slhp_pkg::OP_MAC;
        req.a   = s_sel;
        req.b   = 64'(coef_mag);
        req.sub = coef[15];
      end
      S_PDIV: begin
        req.op   = slhp_pkg::OP_DIV;
        req.a    = acc_mag;
        req.b    = w_mag;
        req.neg  = alu_acc[63] ^ w_dot[63];
        req.frac = slhp_pkg::FRAC_SCALE;
      end
      default: ;
    endcase
  end

  slhp_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .done   (alu_done),
    .acc    (alu_acc),
    .result (alu_res)
  );

  assign in_ready = (state == S_IDLE);

  logic failed_next;
  assign failed_next = ((idx == 2'd0) ? 1'b0 : set_failed) | inf;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issued     <= 1'b0;
      set_failed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // A load in the output state replaces the departing result itself.
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (op_state) begin
        if (!issued) begin
          issued <= 1'b1;
        end else if (alu_done) begin
          issued <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: state <= inf ? S_STORE : S_XMUL;
        S_XMUL:  if (issued && alu_done) state <= S_XDIV;
        S_XDIV:  if (issued && alu_done) state <= S_YMUL;
        S_YMUL:  if (issued && alu_done) state <= S_YDIV;
        S_YDIV: begin
          if (issued && alu_done) begin
            state <= (half_fov_tangent == 20'd0) ? S_STORE : S_ZMUL1;
          end
        end
        S_ZMUL1: if (issued && alu_done) state <= S_ZMUL2;
        S_ZMUL2: if (issued && alu_done) state <= S_ZDIV;
        S_ZDIV:  if (issued && alu_done) state <= S_STORE;
        S_STORE: begin
          if (idx < 2'(slhp_pkg::LED_COUNT)) begin
            set_failed <= failed_next;
            if (idx == 2'(slhp_pkg::LED_COUNT - 1) && !failed_next) begin
              state <= S_PMAC;
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_OUT;
          end
        end
        S_PMAC: begin
          if (issued && alu_done && col == 2'd3) begin
            state <= S_PROW;
          end
        end
        S_PROW: begin
          if (row == 2'd3) begin
            state <= (alu_acc == 64'sd0) ? S_OUT : S_PMAC;
          end else begin
            state <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (issued && alu_done) begin
            state <= (row == 2'd2 && pass) ? S_OUT : S_PMAC;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          idx     <= led_index;
          lx      <= left_x;
          ly      <= left_y;
          rx      <= right_x;
          ry      <= right_y;
          px      <= 32'sd0;
          py      <= 32'sd0;
          pz      <= slhp_pkg::SAT_MAX;
          ready_r <= 1'b0;
          pvalid  <= 1'b0;
        end
      end
      S_XMUL:  if (issued && alu_done) num <= 64'(alu_acc) << 7;
      S_XDIV:  if (issued && alu_done) px <= alu_res;
      S_YMUL:  if (issued && alu_done) num <= 64'(alu_acc) << 7;
      S_YDIV: begin
        if (issued && alu_done) begin
          py <= alu_res;
          if (half_fov_tangent == 20'd0) begin
            pz <= dz_neg ? slhp_pkg::SAT_MIN : slhp_pkg::SAT_MAX;
          end
        end
      end
      S_ZMUL1: if (issued && alu_done) num <= 64'(alu_acc) << 27;
      S_ZMUL2: if (issued && alu_done) den <= 64'(alu_acc);
      S_ZDIV:  if (issued && alu_done) pz <= alu_res;
      S_STORE: begin
        if (idx < 2'(slhp_pkg::LED_COUNT)) begin
          stored_x[idx] <= px;
          stored_y[idx] <= py;
          stored_z[idx] <= pz;
          if (idx == 2'(slhp_pkg::LED_COUNT - 1)) begin
            ready_r <= 1'b1;
          end
        end
        pass <= 1'b0;
        row  <= 2'd3;
        col  <= 2'd0;
      end
      S_PMAC: begin
        if (issued && alu_done && col != 2'd3) begin
          col <= col + 2'd1;
        end
      end
      S_PROW: begin
        if (row == 2'd3) begin
          w_dot <= alu_acc;
          row   <= 2'd0;
          col   <= 2'd0;
        end
      end
      S_PDIV: begin
        if (issued && alu_done) begin
          if (pass) begin
            look_r[row] <= alu_res;
          end else begin
            head_r[row] <= alu_res;
          end
          col <= 2'd0;
          if (row == 2'd2) begin
            if (pass) begin
              pvalid <= 1'b1;
            end else begin
              pass <= 1'b1;
              row  <= 2'd3;
            end
          end else begin
            row <= row + 2'd1;
          end
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          led_x       <= px;
          led_y       <= py;
          led_z       <= pz;
          at_infinity <= inf;
          pose_ready  <= ready_r;
          pose_valid  <= pvalid;
          head_x      <= pvalid ? head_r[0] : 32'sd0;
          head_y      <= pvalid ? head_r[1] : 32'sd0;
          head_z      <= pvalid ? head_r[2] : 32'sd0;
          look_x      <= pvalid ? look_r[0] : 32'sd0;
          look_y      <= pvalid ? look_r[1] : 32'sd0;
          look_z      <= pvalid ? look_r[2] : 32'sd0;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/slhp_alu.sv
// Shared shift-add multiplier and restoring divider. One add or subtract per cycle.
module slhp_alu (
  input  logic                  clk,
  input  logic                  rst,
  input  slhp_pkg::alu_req_t    req,
  output logic                  done,
  output logic signed [63:0]    acc,
  output logic signed [31:0]    result
);

  logic               busy;
  logic               is_div;
  logic signed [63:0] mcand;
  logic [63:0]        mplier;
  logic               sub;
  logic [63:0]        dvd;
  logic [63:0]        den;
  logic [63:0]        rem;
  logic [63:0]        quo;
  logic               big;
  logic               neg;
  logic [6:0]         cnt;
  logic [6:0]         last;

  logic [64:0]        rem_sh;
  logic [65:0]        diff;
  logic               ge;
  logic [63:0]        quo_next;
  logic [33:0]        rnd;
  logic [32:0]        mag;

  assign rem_sh   = {rem, dvd[63]};
  assign diff     = {1'b0, rem_sh} - {2'b00, den};
  assign ge       = ~diff[65];
  assign quo_next = {quo[62:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      is_div <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          busy   <= 1'b1;
          is_div <= (req.op == slhp_pkg::OP_DIV);
        end
      end else if (is_div) begin
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (mplier == 64'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      mcand  <= req.a;
      mplier <= req.b;
      sub    <= req.sub;
      if (req.op == slhp_pkg::OP_MUL) begin
        acc <= 64'sd0;
      end
      dvd  <= req.a;
      den  <= req.b;
      rem  <= 64'd0;
      quo  <= 64'd0;
      big  <= 1'b0;
      neg  <= req.neg;
      cnt  <= 7'd0;
      last <= 7'd63 + {2'b00, req.frac};
    end else if (busy) begin
      if (is_div) begin
        rem <= ge ? diff[63:0] : rem_sh[63:0];
        quo <= quo_next;
        big <= big | (|quo_next[63:33]);
        dvd <= {dvd[62:0], 1'b0};
        cnt <= cnt + 7'd1;
      end else if (mplier != 64'd0) begin
        if (mplier[0]) begin
          acc <= acc + (mcand ^ {64{sub}}) + {63'd0, sub};
        end
        mcand  <= {mcand[62:0], 1'b0};
        mplier <= {1'b0, mplier[63:1]};
      end
    end
  end

  // Round half away from zero from the one extra quotient bit, then saturate.
  assign rnd = {1'b0, quo[32:0]} + 34'd1;
  assign mag = rnd[33:1];

  always_comb begin
    if (neg) begin
      if (big || mag >= 33'h0_8000_0000) begin
        result = slhp_pkg::SAT_MIN;
      end else begin
        result = -$signed(mag[31:0]);
      end
    end else begin
      if (big || mag > 33'h0_7FFF_FFFF) begin
        result = slhp_pkg::SAT_MAX;
      end else begin
        result = $signed(mag[31:0]);
      end
    end
  end

endmodule
